[design/olt_pkg.sv]
// Shared constants and types for the ordered list table.
package olt_pkg;

	// List geometry.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int DATA_W   = 32;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_POP_BACK   = 3'd1,
		REQ_PUSH_FRONT = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_INSERT     = 3'd4,
		REQ_ERASE      = 3'd5,
		REQ_FIND       = 3'd6,
		REQ_MODIFY     = 3'd7
	} req_t;

	// Status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Found index reported when nothing matches (-1).
	localparam logic [IDX_W:0] NOT_FOUND = '1;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_UP   = 4'b0010,
		S_DOWN = 4'b0100,
		S_FIND = 4'b1000
	} state_t;

endpackage

[design/olt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module olt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[design/ordered_list_table.sv]
// Top level of the ordered list table: request sequencer around one entry RAM.
//
// A request word is taken when start is high and busy is low; its result word
// appears on status, found_index and count for exactly one cycle, marked by
// done, and must be captured then because the block cannot be held off. Push
// back, pop back, modify, an append at the count, the removal of the last
// entry, a find on an empty list and every rejected request raise done in the
// cycle after they are taken. Otherwise insert and push front move each entry
// from the back down to the position up one and then write the new entry, erase
// and pop front move each entry past the position down one, and a find compares
// entries from the front until the first match or the last entry. The single
// entry RAM gives one read and one write per cycle, so entries are moved or
// compared one a cycle. busy stays high until the cycle in which done is raised,
// and a new word can be taken in that cycle.
module ordered_list_table
	import olt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               req_type,
	input  logic [IDX_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [IDX_W:0]    found_index,
	output logic [CNT_W-1:0]         count
);

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     rd_q;
	logic [IDX_W-1:0]     prev_q;
	logic                 rd_on_q;
	logic                 pv_q;
	logic [IDX_W-1:0]     pos_q;
	logic [DATA_W-1:0]    val_q;
	logic                 done_q;
	status_t              status_q;
	logic [IDX_W:0]       found_q;

	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [DATA_W-1:0]    wdata;
	logic [DATA_W-1:0]    rdata;

	req_t                 req;
	logic                 accept;
	logic                 full;
	logic                 empty;
	logic [IDX_W-1:0]     eff_pos;
	logic [CNT_W-1:0]     cnt_m1;
	logic [IDX_W-1:0]     last_idx;

	// Request decode and list condition.
	assign req      = req_t'(req_type);
	assign accept   = start && (state_q == S_IDLE);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign eff_pos  = (req == REQ_PUSH_FRONT || req == REQ_POP_FRONT) ? '0 : position;
	assign cnt_m1   = count_q - 1'b1;
	assign last_idx = cnt_m1[IDX_W-1:0];

	// Entry storage.
	olt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_q),
		.rdata(rdata)
	);

	// Write port control: direct stores on accept, moved entries while shifting.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = value;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req)
						REQ_PUSH_BACK: begin
							we    = !full;
							waddr = count_q[IDX_W-1:0];
						end
						REQ_PUSH_FRONT, REQ_INSERT: begin
							we    = !full && ({1'b0, eff_pos} == count_q);
							waddr = eff_pos;
						end
						REQ_MODIFY: begin
							we    = !empty && ({1'b0, eff_pos} < count_q);
							waddr = eff_pos;
						end
						default: begin
							we = 1'b0;
						end
					endcase
				end
			end
			S_UP: begin
				if (pv_q) begin
					we    = 1'b1;
					waddr = prev_q + 1'b1;
					wdata = rdata;
				end else if (!rd_on_q) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = val_q;
				end
			end
			S_DOWN: begin
				if (pv_q) begin
					we    = 1'b1;
					waddr = prev_q - 1'b1;
					wdata = rdata;
				end
			end
			S_FIND: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_on_q  <= 1'b0;
			pv_q     <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			found_q  <= NOT_FOUND;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q    <= eff_pos;
						val_q    <= value;
						pv_q     <= 1'b0;
						rd_on_q  <= 1'b1;
						status_q <= ST_OK;
						found_q  <= NOT_FOUND;
						unique case (req)
							REQ_PUSH_BACK: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							REQ_POP_BACK: begin
								done_q <= 1'b1;
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= cnt_m1;
								end
							end
							REQ_PUSH_FRONT, REQ_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
									done_q   <= 1'b1;
								end else if ({1'b0, eff_pos} > count_q) begin
									status_q <= ST_RANGE;
									done_q   <= 1'b1;
								end else if ({1'b0, eff_pos} == count_q) begin
									count_q <= count_q + 1'b1;
									done_q  <= 1'b1;
								end else begin
									rd_q    <= last_idx;
									state_q <= S_UP;
								end
							end
							REQ_POP_FRONT, REQ_ERASE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
									done_q   <= 1'b1;
								end else if ({1'b0, eff_pos} >= count_q) begin
									status_q <= ST_RANGE;
									done_q   <= 1'b1;
								end else if (eff_pos == last_idx) begin
									count_q <= cnt_m1;
									done_q  <= 1'b1;
								end else begin
									rd_q    <= eff_pos + 1'b1;
									state_q <= S_DOWN;
								end
							end
							REQ_FIND: begin
								if (empty) begin
									done_q <= 1'b1;
								end else begin
									rd_q    <= '0;
									state_q <= S_FIND;
								end
							end
							REQ_MODIFY: begin
								done_q <= 1'b1;
								if (empty) begin
									status_q <= ST_EMPTY;
								end else if ({1'b0, eff_pos} >= count_q) begin
									status_q <= ST_RANGE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end

				// Move entries up one, from the back down to the insert position, then write the new entry.
				S_UP: begin
					if (rd_on_q) begin
						prev_q <= rd_q;
						pv_q   <= 1'b1;
						if (rd_q == pos_q) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_q <= rd_q - 1'b1;
						end
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							count_q <= count_q + 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end

				// Move entries down one, from just past the erased entry to the back.
				S_DOWN: begin
					if (rd_on_q) begin
						prev_q <= rd_q;
						pv_q   <= 1'b1;
						if (rd_q == last_idx) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_q <= rd_q + 1'b1;
						end
					end else begin
						pv_q <= 1'b0;
						if (pv_q) begin
							count_q <= cnt_m1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end

				// Compare one entry a cycle against the key, front to back.
				S_FIND: begin
					if (pv_q && (rdata == val_q)) begin
						found_q <= {1'b0, prev_q};
						done_q  <= 1'b1;
						pv_q    <= 1'b0;
						state_q <= S_IDLE;
					end else if (pv_q && (prev_q == last_idx)) begin
						done_q  <= 1'b1;
						pv_q    <= 1'b0;
						state_q <= S_IDLE;
					end else if (rd_on_q) begin
						prev_q <= rd_q;
						pv_q   <= 1'b1;
						if (rd_q == last_idx) begin
							rd_on_q <= 1'b0;
						end else begin
							rd_q <= rd_q + 1'b1;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word.
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign count       = count_q;

endmodule

[sim/ordered_list_table_tb.sv]
// Self-checking testbench for the ordered list table: directed and random request words.
module ordered_list_table_tb
	import olt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One result word as the block reports it.
	typedef struct packed {
		status_t              status;
		logic [IDX_W:0]       found_index;
		logic [CNT_W-1:0]     count;
	} list_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [2:0]               req_type = REQ_PUSH_BACK;
	logic [IDX_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     done;
	logic [1:0]               status;
	logic signed [IDX_W:0]    found_index;
	logic [CNT_W-1:0]         count;

	// Shadow copy of the list, updated as each request word is accepted.
	logic [DATA_W-1:0] model_words [CAPACITY];
	int                model_len = 0;

	list_result_t awaited_outcomes [$];
	int           mismatch_count = 0;
	int           sender_idle_pct = 0;

	ordered_list_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.count       (count)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow list and return the word the block should report.
	function automatic list_result_t apply_request(req_t op, logic [IDX_W-1:0] pos,
			logic [DATA_W-1:0] word);
		list_result_t res;
		int i;
		bit hit;
		res.status = ST_OK;
		res.found_index = NOT_FOUND;
		hit = 1'b0;
		case (op)
			REQ_PUSH_BACK: begin
				if (model_len == CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					model_words[model_len] = word;
					model_len++;
				end
			end
			REQ_POP_BACK: begin
				if (model_len == 0) res.status = ST_EMPTY;
				else model_len--;
			end
			REQ_PUSH_FRONT: begin
				if (model_len == CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = model_len; i > 0; i--) model_words[i] = model_words[i-1];
					model_words[0] = word;
					model_len++;
				end
			end
			REQ_POP_FRONT: begin
				if (model_len == 0) begin
					res.status = ST_EMPTY;
				end else begin
					for (i = 0; i < model_len - 1; i++) model_words[i] = model_words[i+1];
					model_len--;
				end
			end
			REQ_INSERT: begin
				// A full list is rejected before the position is looked at.
				if (model_len == CAPACITY) begin
					res.status = ST_FULL;
				end else if (pos > model_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = model_len; i > pos; i--) model_words[i] = model_words[i-1];
					model_words[pos] = word;
					model_len++;
				end
			end
			REQ_ERASE: begin
				if (model_len == 0) begin
					res.status = ST_EMPTY;
				end else if (pos >= model_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = pos; i < model_len - 1; i++) model_words[i] = model_words[i+1];
					model_len--;
				end
			end
			REQ_FIND: begin
				// First match wins; an empty list simply reports a miss.
				for (i = 0; i < model_len && !hit; i++) begin
					if (model_words[i] == word) begin
						res.found_index = i[IDX_W:0];
						hit = 1'b1;
					end
				end
			end
			REQ_MODIFY: begin
				if (model_len == 0) res.status = ST_EMPTY;
				else if (pos >= model_len) res.status = ST_RANGE;
				else model_words[pos] = word;
			end
		endcase
		res.count = model_len[CNT_W-1:0];
		return res;
	endfunction

	// Offer one request word, with a random gap first, and record its expected result.
	task automatic send_word(req_t op, logic [IDX_W-1:0] pos, logic [DATA_W-1:0] word);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		req_type <= op;
		position <= pos;
		value <= word;
		do @(posedge clk); while (busy);
		awaited_outcomes.push_back(apply_request(op, pos, word));
	endtask

	// Sample each result word at the rising edge and compare it at the following falling edge.
	always begin : result_check
		list_result_t got;
		list_result_t want;
		logic seen;
		@(posedge clk);
		seen = arst_n && done;
		got.status = status_t'(status);
		got.found_index = found_index;
		got.count = count;
		@(negedge clk);
		if (seen === 1'b1) begin
			if (awaited_outcomes.size() == 0) begin
				$error("result word arrived with no request outstanding");
				mismatch_count++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.found_index !== want.found_index) begin
					$error("found_index: expected %0d, actual %0d",
						$signed(want.found_index), $signed(got.found_index));
					mismatch_count++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, got.count);
					mismatch_count++;
				end
			end
		end
	end

	// An empty list rejects every request that needs entries; a find on it just misses.
	task automatic test_empty_list_rejects();
		send_word(REQ_POP_BACK, '0, '0);
		send_word(REQ_POP_FRONT, '0, '0);
		send_word(REQ_ERASE, '0, 32'h0000_0001);
		send_word(REQ_MODIFY, '0, 32'h0000_0002);
		send_word(REQ_FIND, '0, '0);
		send_word(REQ_INSERT, 6'd1, 32'h0000_0003);
		send_word(REQ_INSERT, 6'd63, 32'h0000_0004);
	endtask

	// Build a short list from extreme words and walk every edit across it.
	task automatic test_edits_on_short_list();
		send_word(REQ_INSERT, '0, 32'h8000_0000);
		send_word(REQ_PUSH_BACK, 6'd63, 32'h7FFF_FFFF);
		send_word(REQ_PUSH_FRONT, 6'd17, 32'hFFFF_FFFF);
		send_word(REQ_PUSH_BACK, '0, 32'h0000_0000);
		// Appending at the count is legal and creates a duplicate.
		send_word(REQ_INSERT, 6'd4, 32'h7FFF_FFFF);
		send_word(REQ_FIND, '0, 32'h7FFF_FFFF);
		send_word(REQ_FIND, '0, 32'h1234_5678);
		send_word(REQ_MODIFY, 6'd2, 32'h5A5A_5A5A);
		send_word(REQ_MODIFY, 6'd5, 32'hA5A5_A5A5);
		send_word(REQ_ERASE, 6'd5, '0);
		send_word(REQ_ERASE, 6'd63, '0);
		send_word(REQ_INSERT, 6'd6, 32'h0000_0009);
		send_word(REQ_ERASE, 6'd1, '0);
		send_word(REQ_POP_FRONT, '0, '0);
		send_word(REQ_POP_BACK, '0, '0);
		send_word(REQ_FIND, '0, 32'h5A5A_5A5A);
	endtask

	// Random traffic that sweeps the list between empty and full.
	task automatic test_random_traffic(int idle_pct, int n_items);
		int k;
		int roll;
		bit grow;
		req_t op;
		logic [IDX_W-1:0] pos;
		logic [DATA_W-1:0] word;
		sender_idle_pct = idle_pct;
		grow = 1'b1;
		for (k = 0; k < n_items; k++) begin
			// Switch direction now and then so both the full and the empty list are held.
			if (k % 150 == 0) grow = (model_len < CAPACITY / 2);

			// Words come from a small pool often enough to make duplicates for find.
			roll = $urandom_range(9);
			if (roll < 4) begin
				word = $urandom;
			end else if (roll < 7) begin
				word = $urandom_range(7);
			end else begin
				case ($urandom_range(3))
					0: word = 32'h0000_0000;
					1: word = 32'hFFFF_FFFF;
					2: word = 32'h8000_0000;
					default: word = 32'h7FFF_FFFF;
				endcase
			end

			roll = $urandom_range(99);
			if (roll < 8) begin
				// Noise: any code, any position.
				op = req_t'($urandom_range(7));
				pos = IDX_W'($urandom_range(CAPACITY - 1));
			end else begin
				roll = $urandom_range(99);
				if (grow)
					op = roll < 25 ? REQ_PUSH_BACK : roll < 45 ? REQ_PUSH_FRONT :
						roll < 70 ? REQ_INSERT : roll < 75 ? REQ_POP_BACK :
						roll < 78 ? REQ_POP_FRONT : roll < 82 ? REQ_ERASE :
						roll < 92 ? REQ_FIND : REQ_MODIFY;
				else
					op = roll < 25 ? REQ_POP_BACK : roll < 45 ? REQ_POP_FRONT :
						roll < 70 ? REQ_ERASE : roll < 75 ? REQ_PUSH_BACK :
						roll < 78 ? REQ_PUSH_FRONT : roll < 82 ? REQ_INSERT :
						roll < 92 ? REQ_FIND : REQ_MODIFY;

				// Mostly legal positions, with an occasional one anywhere.
				if ($urandom_range(9) == 0 || model_len == CAPACITY)
					pos = IDX_W'($urandom_range(CAPACITY - 1));
				else if (op == REQ_INSERT)
					pos = IDX_W'($urandom_range(model_len));
				else if (model_len != 0)
					pos = IDX_W'($urandom_range(model_len - 1));
				else
					pos = '0;

				if (op == REQ_FIND && model_len != 0 && $urandom_range(1) == 1)
					word = model_words[$urandom_range(model_len - 1)];
			end
			send_word(op, pos, word);
		end
	endtask

	// Test sequence.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 10;
		test_empty_list_rejects();
		test_edits_on_short_list();
		test_random_traffic(10, 380);
		test_random_traffic(68, 380);
		test_random_traffic(0, 370);
		start <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
design/olt_pkg.sv
design/olt_ram.sv
design/ordered_list_table.sv
sim/ordered_list_table_tb.sv
